[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define MCRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcrs assertion failed");

// Implication in the next cycle, disabled during reset.
`define MCRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcrs assertion failed");

`endif

[design/mcrs_pkg.sv]
// Package: opcodes, selectors, constants and types of the code reference scanner.
`default_nettype none

package mcrs_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned XLEN      = 32;
  localparam int unsigned SIZE_W    = 29;
  localparam int unsigned TGT_W     = 28;

  // Configuration register indexes
  localparam logic CFG_MEM_BASE   = 1'b0;
  localparam logic CFG_IMAGE_SIZE = 1'b1;

  localparam logic [XLEN-1:0] BASE_RESET = 32'h8000_0000;
  localparam logic [TGT_W-1:0] FUNC_LOW  = 28'h000_0190;

  // Primary opcodes
  localparam logic [5:0] OP_REGIMM = 6'h01;
  localparam logic [5:0] OP_J      = 6'h02;
  localparam logic [5:0] OP_JAL    = 6'h03;
  localparam logic [5:0] OP_BEQ    = 6'h04;
  localparam logic [5:0] OP_BNE    = 6'h05;
  localparam logic [5:0] OP_BLEZ   = 6'h06;
  localparam logic [5:0] OP_BGTZ   = 6'h07;
  localparam logic [5:0] OP_ADDI   = 6'h08;
  localparam logic [5:0] OP_ADDIU  = 6'h09;
  localparam logic [5:0] OP_ORI    = 6'h0D;
  localparam logic [5:0] OP_LUI    = 6'h0F;
  localparam logic [5:0] OP_COP1   = 6'h11;
  localparam logic [5:0] OP_BEQL   = 6'h14;
  localparam logic [5:0] OP_BNEL   = 6'h15;
  localparam logic [5:0] OP_BLEZL  = 6'h16;
  localparam logic [5:0] OP_BGTZL  = 6'h17;

  // COP1 rs selector of the BC1 branch group
  localparam logic [4:0] COP1_BC = 5'h08;

  typedef struct packed {
    logic             is_branch;
    logic             is_call;
    logic [TGT_W-1:0] call_target;
    logic             new_function;
    logic             reg_write;
    logic             is_ref;
    logic [XLEN-1:0]  value;
  } exec_res_t;

endpackage

`default_nettype wire

[design/mips_code_reference_scanner_core.sv]
// Top level: MIPS code reference scanner with a memory-backed register file.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+---------------------------------
//   in       | sink      | in_valid_i / in_stall_o   | instr_word_i, image_start_i
//   out      | source    | out_valid_o / out_stall_i | instr_address_o ... ref_total_o
//   cfg      | sink      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the output stalls; an accepted item enters the
// execute stage with its register file read and executes into the output register.
// The register file read port sets the pace: the read issues as the item is
// accepted and a write from the item ahead is bypassed.
// Reset clears control state, counters and the valid bits of the register file;
// an entry never written reads as zero, so no clearing pass is needed.
// A stalled output holds the execute stage, and the input stalls only then.
`default_nettype none

module mips_code_reference_scanner_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instr_word_i,
  input  wire logic        image_start_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      instr_address_o,
  output logic             is_branch_o,
  output logic             is_call_o,
  output logic [27:0]      call_target_o,
  output logic             new_function_o,
  output logic             is_address_ref_o,
  output logic [31:0]      ref_value_o,
  output logic [31:0]      branch_total_o,
  output logic [31:0]      call_total_o,
  output logic [31:0]      ref_total_o
);

  localparam int unsigned XW = mcrs_pkg::XLEN;
  localparam int unsigned AW = mcrs_pkg::REG_AW;

  // configuration and window limit
  logic [XW-1:0]               mem_base_q;
  logic [mcrs_pkg::SIZE_W-1:0] image_size_q;
  logic [XW:0]                 win_hi_q;

  // fetch side
  logic [XW-1:0] pc_q;
  logic [XW-1:0] cur_addr;
  logic          in_acc;

  // execute stage
  logic          s1_valid_q;
  logic [XW-1:0] s1_word_q;
  logic [XW-1:0] s1_addr_q;
  logic          commit;

  // register file
  logic [mcrs_pkg::REG_COUNT-1:0] vld_q;
  logic                           rvld_q;
  logic                           byp_hit_q;
  logic [XW-1:0]                  byp_data_q;
  logic [XW-1:0]                  ram_rdata;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [XW-1:0]                  src;

  mcrs_pkg::exec_res_t res;

  // counters
  logic [XW-1:0] br_cnt_q, br_cnt_d;
  logic [XW-1:0] call_cnt_q, call_cnt_d;
  logic [XW-1:0] ref_cnt_q, ref_cnt_d;

  logic out_valid_q;

  // ---------------------------------------------------------------- handshake
  // Advance the execute stage whenever the output register is free or drains.
  assign commit     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !commit;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ------------------------------------------------------------ configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_base_q   <= mcrs_pkg::BASE_RESET;
      image_size_q <= '0;
      win_hi_q     <= {1'b0, mcrs_pkg::BASE_RESET};
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mcrs_pkg::CFG_MEM_BASE:   mem_base_q   <= cfg_data_i;
          mcrs_pkg::CFG_IMAGE_SIZE: image_size_q <= cfg_data_i[mcrs_pkg::SIZE_W-1:0];
          default:                  mem_base_q   <= mem_base_q;
        endcase
      end
      // Upper window bound carries one extra bit so the window never wraps.
      win_hi_q <= {1'b0, mem_base_q} + {{(XW + 1 - mcrs_pkg::SIZE_W){1'b0}}, image_size_q};
    end
  end

  // ------------------------------------------------------------ program counter
  assign cur_addr = image_start_i ? mem_base_q : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mcrs_pkg::BASE_RESET;
    end else if (in_acc) begin
      pc_q <= cur_addr + XW'(4);
    end
  end

  // ---------------------------------------------------------- execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (commit) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= instr_word_i;
      s1_addr_q <= cur_addr;
    end
  end

  // ------------------------------------------------------------ register file
  // Read rs as the item is accepted; write rt when the item commits.
  assign ram_we    = commit && res.reg_write;
  assign ram_waddr = s1_word_q[20:16];

  mcrs_ram #(
    .DEPTH (mcrs_pkg::REG_COUNT),
    .WIDTH (XW)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (res.value),
    .re_i    (in_acc),
    .raddr_i (instr_word_i[25:21]),
    .rdata_o (ram_rdata)
  );

  // Valid bits stand in for the all-zero reset of the file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr] <= 1'b1;
    end
  end

  // Catch a write that lands in the same edge as the read (read sees old data).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= 1'b0;
      byp_hit_q <= 1'b0;
    end else if (in_acc) begin
      rvld_q    <= vld_q[instr_word_i[25:21]];
      byp_hit_q <= ram_we && (ram_waddr == instr_word_i[25:21]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= res.value;
    end
  end

  assign src = byp_hit_q ? byp_data_q : (rvld_q ? ram_rdata : '0);

  mcrs_exec u_exec (
    .word_i       (s1_word_q),
    .src_i        (src),
    .win_lo_i     (mem_base_q),
    .win_hi_i     (win_hi_q),
    .image_size_i (image_size_q),
    .res_o        (res)
  );

  // ---------------------------------------------------------------- counters
  always_comb begin
    br_cnt_d   = br_cnt_q;
    call_cnt_d = call_cnt_q;
    ref_cnt_d  = ref_cnt_q;
    // Saturate at all ones.
    if (res.is_branch && (br_cnt_q != '1)) begin
      br_cnt_d = br_cnt_q + XW'(1);
    end
    if (res.is_call && (call_cnt_q != '1)) begin
      call_cnt_d = call_cnt_q + XW'(1);
    end
    if (res.is_ref && (ref_cnt_q != '1)) begin
      ref_cnt_d = ref_cnt_q + XW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_cnt_q   <= '0;
      call_cnt_q <= '0;
      ref_cnt_q  <= '0;
    end else if (commit) begin
      br_cnt_q   <= br_cnt_d;
      call_cnt_q <= call_cnt_d;
      ref_cnt_q  <= ref_cnt_d;
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= commit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      instr_address_o  <= s1_addr_q;
      is_branch_o      <= res.is_branch;
      is_call_o        <= res.is_call;
      call_target_o    <= res.call_target;
      new_function_o   <= res.new_function;
      is_address_ref_o <= res.is_ref;
      ref_value_o      <= res.value;
      branch_total_o   <= br_cnt_d;
      call_total_o     <= call_cnt_d;
      ref_total_o      <= ref_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[design/mcrs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mcrs_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/mcrs_exec.sv]
// Execute unit: decode one word, form the register value and the flags.
`default_nettype none

module mcrs_exec (
  input  wire logic [mcrs_pkg::XLEN-1:0]   word_i,
  input  wire logic [mcrs_pkg::XLEN-1:0]   src_i,
  input  wire logic [mcrs_pkg::XLEN-1:0]   win_lo_i,
  input  wire logic [mcrs_pkg::XLEN:0]     win_hi_i,
  input  wire logic [mcrs_pkg::SIZE_W-1:0] image_size_i,
  output mcrs_pkg::exec_res_t              res_o
);

  logic [5:0]                    op;
  logic [4:0]                    rs;
  logic [4:0]                    rt;
  logic [15:0]                   imm;
  logic [mcrs_pkg::XLEN-1:0]     simm;
  logic [mcrs_pkg::TGT_W-1:0]    target;
  logic                          branch;

  assign op     = word_i[31:26];
  assign rs     = word_i[25:21];
  assign rt     = word_i[20:16];
  assign imm    = word_i[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign target = {word_i[25:0], 2'b00};

  always_comb begin
    unique case (op) inside
      mcrs_pkg::OP_REGIMM: begin
        // rt selectors 0 to 3 and 8 to 11 of the regimm group
        branch = (!rt[4] && !rt[2]) || (rt[4:2] == 3'b010);
      end
      mcrs_pkg::OP_J, mcrs_pkg::OP_BEQ, mcrs_pkg::OP_BNE, mcrs_pkg::OP_BLEZ,
      mcrs_pkg::OP_BGTZ, mcrs_pkg::OP_BEQL, mcrs_pkg::OP_BNEL,
      mcrs_pkg::OP_BLEZL, mcrs_pkg::OP_BGTZL: begin
        branch = 1'b1;
      end
      mcrs_pkg::OP_COP1: begin
        branch = (rs == mcrs_pkg::COP1_BC);
      end
      default: begin
        branch = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.is_branch    = branch;
    if (!branch) begin
      unique case (op) inside
        mcrs_pkg::OP_JAL: begin
          res_o.is_call      = 1'b1;
          res_o.call_target  = target;
          res_o.new_function = (target >= mcrs_pkg::FUNC_LOW) &&
                               ({1'b0, target} < image_size_i);
        end
        mcrs_pkg::OP_LUI: begin
          res_o.reg_write = 1'b1;
          res_o.value     = {imm, 16'h0000};
        end
        mcrs_pkg::OP_ADDI, mcrs_pkg::OP_ADDIU, mcrs_pkg::OP_ORI: begin
          res_o.reg_write = 1'b1;
          res_o.value     = (op == mcrs_pkg::OP_ORI) ? (src_i | {16'h0000, imm})
                                                     : (src_i + simm);
          res_o.is_ref    = (res_o.value >= win_lo_i) &&
                            ({1'b0, res_o.value} < win_hi_i);
        end
        default: begin
          res_o.reg_write = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/mcrs_checker.sv]
// Checker on the scanner ports, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mcrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] instr_address_o,
  input wire logic        is_branch_o,
  input wire logic        is_call_o,
  input wire logic [27:0] call_target_o,
  input wire logic        new_function_o,
  input wire logic        is_address_ref_o,
  input wire logic [31:0] ref_total_o
);

  `MCRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(instr_address_o) && $stable(ref_total_o))
  `MCRS_ASSERT_NOW(a_kind_excl, clk_i, rst_ni, out_valid_o, !(is_branch_o && is_call_o))
  `MCRS_ASSERT_NOW(a_no_call_clear, clk_i, rst_ni, out_valid_o && !is_call_o, (call_target_o == 28'd0) && !new_function_o)
  `MCRS_ASSERT_NOW(a_ref_counted, clk_i, rst_ni, out_valid_o && is_address_ref_o, ref_total_o != 32'd0)

endmodule

bind mips_code_reference_scanner_core mcrs_checker u_mcrs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .instr_address_o  (instr_address_o),
  .is_branch_o      (is_branch_o),
  .is_call_o        (is_call_o),
  .call_target_o    (call_target_o),
  .new_function_o   (new_function_o),
  .is_address_ref_o (is_address_ref_o),
  .ref_total_o      (ref_total_o)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the MIPS code reference scanner core.
`timescale 1ns / 1ps

module testbench;

  // Opcode that no decoder case claims
  localparam logic [5:0] OP_UNUSED = 6'h3F;
  // Cycles with no item moving on either channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [31:0] word;
    logic        start;
  } instr_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        is_branch;
    logic        is_call;
    logic [27:0] target;
    logic        new_func;
    logic        ref_hit;
    logic [31:0] value;
    logic [31:0] branches;
    logic [31:0] calls;
    logic [31:0] refs;
  } scan_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = mcrs_pkg::CFG_MEM_BASE;
  logic [31:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] instr_word_i  = '0;
  logic        image_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] instr_address_o;
  logic        is_branch_o;
  logic        is_call_o;
  logic [27:0] call_target_o;
  logic        new_function_o;
  logic        is_address_ref_o;
  logic [31:0] ref_value_o;
  logic [31:0] branch_total_o;
  logic [31:0] call_total_o;
  logic [31:0] ref_total_o;

  mips_code_reference_scanner_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .instr_word_i     (instr_word_i),
    .image_start_i    (image_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .instr_address_o  (instr_address_o),
    .is_branch_o      (is_branch_o),
    .is_call_o        (is_call_o),
    .call_target_o    (call_target_o),
    .new_function_o   (new_function_o),
    .is_address_ref_o (is_address_ref_o),
    .ref_value_o      (ref_value_o),
    .branch_total_o   (branch_total_o),
    .call_total_o     (call_total_o),
    .ref_total_o      (ref_total_o)
  );

  // Instruction words waiting to be offered, and scan results still owed by the block
  instr_item_t word_q[$];
  scan_t       scan_q[$];

  // Shadow copy of the scanner: configuration, register file, program counter, counters
  logic [31:0]                 base_cfg;
  logic [mcrs_pkg::SIZE_W-1:0] size_cfg;
  logic [31:0]                 gpr_model [mcrs_pkg::REG_COUNT];
  logic [31:0]                 pc_model;
  logic [31:0]                 branch_cnt;
  logic [31:0]                 call_cnt;
  logic [31:0]                 ref_cnt;

  logic [5:0] cond_ops [8] = '{mcrs_pkg::OP_BEQ, mcrs_pkg::OP_BNE, mcrs_pkg::OP_BLEZ,
                               mcrs_pkg::OP_BGTZ, mcrs_pkg::OP_BEQL, mcrs_pkg::OP_BNEL,
                               mcrs_pkg::OP_BLEZL, mcrs_pkg::OP_BGTZL};

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned in_gap         = 0;
  int unsigned stall_gap      = 0;
  int unsigned hold_left      = 0;
  int unsigned next_hold_at   = 400;
  bit          calm           = 1'b0;
  bit          lead_start     = 1'b0;
  scan_t       head;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Scan one word against the shadow state: decode, update registers and counters,
  // advance the program counter, and return what the block must report.
  function automatic scan_t scan_word(input logic [31:0] w, input logic start);
    scan_t       r;
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] src;
    logic [32:0] lo;
    logic [32:0] hi;
    logic        hit_branch;
    op  = w[31:26];
    rs  = w[25:21];
    rt  = w[20:16];
    imm = w[15:0];
    r   = '0;
    if (start) pc_model = base_cfg;
    r.addr = pc_model;
    case (op) inside
      mcrs_pkg::OP_REGIMM: begin
        hit_branch = ((rt & 5'h14) == 5'h00) || ((rt & 5'h1C) == 5'h08);
      end
      mcrs_pkg::OP_J, mcrs_pkg::OP_BEQ, mcrs_pkg::OP_BNE, mcrs_pkg::OP_BLEZ,
      mcrs_pkg::OP_BGTZ, mcrs_pkg::OP_BEQL, mcrs_pkg::OP_BNEL, mcrs_pkg::OP_BLEZL,
      mcrs_pkg::OP_BGTZL: begin
        hit_branch = 1'b1;
      end
      mcrs_pkg::OP_COP1: begin
        hit_branch = (rs == mcrs_pkg::COP1_BC);
      end
      default: begin
        hit_branch = 1'b0;
      end
    endcase
    if (hit_branch) begin
      r.is_branch = 1'b1;
      branch_cnt  = sat_up(branch_cnt);
    end else if (op == mcrs_pkg::OP_JAL) begin
      r.is_call   = 1'b1;
      call_cnt    = sat_up(call_cnt);
      r.target    = {w[25:0], 2'b00};
      r.new_func  = (r.target >= mcrs_pkg::FUNC_LOW) && ({1'b0, r.target} < size_cfg);
    end else if (op == mcrs_pkg::OP_LUI) begin
      r.value       = {imm, 16'h0000};
      gpr_model[rt] = r.value;
    end else if (op == mcrs_pkg::OP_ADDI || op == mcrs_pkg::OP_ADDIU ||
                 op == mcrs_pkg::OP_ORI) begin
      src = gpr_model[rs];
      r.value = (op == mcrs_pkg::OP_ORI) ? (src | {16'h0000, imm})
                                         : (src + {{16{imm[15]}}, imm});
      gpr_model[rt] = r.value;
      // Window bound carries one extra bit so it never wraps past the top
      lo = {1'b0, base_cfg};
      hi = lo + {4'b0000, size_cfg};
      if ({1'b0, r.value} >= lo && {1'b0, r.value} < hi) begin
        r.ref_hit = 1'b1;
        ref_cnt   = sat_up(ref_cnt);
      end
    end
    pc_model   = pc_model + 32'd4;
    r.branches = branch_cnt;
    r.calls    = call_cnt;
    r.refs     = ref_cnt;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
    return {op, tgt};
  endfunction

  function automatic void push_word(input logic [31:0] w, input logic start);
    instr_item_t it;
    it.word  = w;
    it.start = start;
    word_q.push_back(it);
  endfunction

  // Queue a random word; any word may reload the program counter at random, the first of a phase whenever asked
  function automatic void push_random(input logic [31:0] w);
    push_word(w, lead_start || ($urandom_range(0, 31) == 0));
    lead_start = 1'b0;
  endfunction

  // Fill the queue with about n words, mostly pointer-building pairs, calls and branches
  function automatic void add_random(input int unsigned n, input bit first_start);
    int unsigned added;
    int unsigned pick;
    logic [31:0] a;
    logic [15:0] upper;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  op;
    logic [25:0] tgt;
    logic [27:0] near;
    added = 0;
    lead_start = first_start;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // LUI then ADDI/ADDIU/ORI building an address in, at or just outside the window
        if (size_cfg != 0 && $urandom_range(0, 3) != 0) begin
          a = base_cfg + $urandom_range(0, size_cfg - 1);
        end else begin
          case ($urandom_range(0, 4))
            0: a = base_cfg + {3'b000, size_cfg};
            1: a = base_cfg - 32'd1;
            2: a = base_cfg;
            3: a = base_cfg + {3'b000, size_cfg} - 32'd1;
            default: a = $urandom;
          endcase
        end
        rt = 5'($urandom_range(0, 31));
        rd = ($urandom_range(0, 1) == 0) ? rt : 5'($urandom_range(0, 31));
        case ($urandom_range(0, 2))
          0: op = mcrs_pkg::OP_ORI;
          1: op = mcrs_pkg::OP_ADDIU;
          default: op = mcrs_pkg::OP_ADDI;
        endcase
        // Sign-extended low half needs the upper half bumped when bit 15 is set
        upper = (op == mcrs_pkg::OP_ORI) ? a[31:16] : a[31:16] + {15'd0, a[15]};
        push_random(enc_i(mcrs_pkg::OP_LUI, 5'($urandom), rt, upper));
        push_random(enc_i(op, rt, rd, a[15:0]));
        added += 2;
      end else if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: tgt = 26'h000_0063 + 26'($urandom_range(0, 2));
          1: begin
            near = (size_cfg[27:0] == 28'd0) ? 28'hFFF_FFFC : size_cfg[27:0];
            tgt  = 26'(near >> 2) + 26'($urandom_range(0, 2)) - 26'd1;
          end
          2: begin
            if (size_cfg > 32'h194) tgt = 26'($urandom_range(32'h64, (size_cfg - 1) >> 2));
            else tgt = 26'($urandom);
          end
          default: tgt = 26'($urandom);
        endcase
        push_random(enc_j(mcrs_pkg::OP_JAL, tgt));
        added += 1;
      end else if (pick < 65) begin
        pick = $urandom_range(0, 10);
        if (pick < 8) op = cond_ops[pick];
        else if (pick == 8) op = mcrs_pkg::OP_J;
        else if (pick == 9) op = mcrs_pkg::OP_REGIMM;
        else op = mcrs_pkg::OP_COP1;
        a = {op, 26'($urandom)};
        if (op == mcrs_pkg::OP_COP1 && $urandom_range(0, 1) == 0) a[25:21] = mcrs_pkg::COP1_BC;
        push_random(a);
        added += 1;
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0: op = mcrs_pkg::OP_LUI;
          1: op = mcrs_pkg::OP_ADDI;
          2: op = mcrs_pkg::OP_ADDIU;
          default: op = mcrs_pkg::OP_ORI;
        endcase
        // Favor a few registers so values chain through earlier writes
        rt = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
        rd = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
        push_random(enc_i(op, rt, rd, 16'($urandom)));
        added += 1;
      end else begin
        push_random($urandom);
        added += 1;
      end
    end
  endfunction

  // Write both registers back to back; only called with nothing in flight
  task automatic set_window(input logic [31:0] base, input logic [31:0] size);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mcrs_pkg::CFG_MEM_BASE;
    cfg_data_i  <= base;
    base_cfg     = base;
    @(posedge clk_i);
    cfg_index_i <= mcrs_pkg::CFG_IMAGE_SIZE;
    cfg_data_i  <= size;
    size_cfg     = size[mcrs_pkg::SIZE_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait until every word is scanned and reported, then let the pipeline settle
  task automatic wait_idle();
    while (word_q.size() != 0 || scan_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sequencer: reset, then phases of stimulus under different windows
  initial begin
    base_cfg   = mcrs_pkg::BASE_RESET;
    size_cfg   = '0;
    pc_model   = mcrs_pkg::BASE_RESET;
    branch_cnt = '0;
    call_cnt   = '0;
    ref_cnt    = '0;
    for (int i = 0; i < mcrs_pkg::REG_COUNT; i++) gpr_model[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words; the first one checks the program counter left by reset
    set_window(mcrs_pkg::BASE_RESET, 32'h0040_0000);
    push_word(enc_i(mcrs_pkg::OP_LUI, 5'd0, 5'd0, 16'h8000), 1'b0);   // register zero takes a value
    push_word(enc_i(mcrs_pkg::OP_ORI, 5'd0, 5'd0, 16'h1234), 1'b0);   // and reads it back
    push_word(enc_i(mcrs_pkg::OP_ADDI, 5'd0, 5'd1, 16'hFFFF), 1'b0);  // negative immediate
    push_word(enc_i(mcrs_pkg::OP_LUI, 5'd0, 5'd3, 16'h8040), 1'b0);
    push_word(enc_i(mcrs_pkg::OP_ADDIU, 5'd3, 5'd4, 16'hFFFF), 1'b0); // last byte of the window
    push_word(enc_i(mcrs_pkg::OP_ORI, 5'd3, 5'd4, 16'h0000), 1'b0);   // first byte past it
    push_word(enc_i(mcrs_pkg::OP_LUI, 5'd0, 5'd31, 16'hFFFF), 1'b1);  // reload the program counter
    push_word(enc_i(mcrs_pkg::OP_ORI, 5'd31, 5'd31, 16'hFFFF), 1'b0);
    push_word(enc_i(mcrs_pkg::OP_ADDIU, 5'd31, 5'd30, 16'h0001), 1'b0); // sum wraps to zero
    push_word(enc_j(mcrs_pkg::OP_J, 26'h3FF_FFFF), 1'b0);
    push_word(enc_j(mcrs_pkg::OP_JAL, 26'h000_0064), 1'b0);           // lowest function address
    push_word(enc_j(mcrs_pkg::OP_JAL, 26'h000_0063), 1'b0);           // just below it
    push_word(enc_j(mcrs_pkg::OP_JAL, 26'h00F_FFFF), 1'b0);           // last word inside the image
    push_word(enc_j(mcrs_pkg::OP_JAL, 26'h010_0000), 1'b0);           // target equals the size
    for (int i = 0; i < 8; i++) begin
      push_word(enc_i(cond_ops[i], 5'(i), 5'(31 - i), (i % 2 == 0) ? 16'hFFFF : 16'h0000),
                1'b0);
    end
    push_word(enc_i(mcrs_pkg::OP_REGIMM, 5'd0, 5'h00, 16'h0010), 1'b0);
    push_word(enc_i(mcrs_pkg::OP_REGIMM, 5'd0, 5'h1F, 16'h0010), 1'b0); // unused selector
    push_word(enc_i(mcrs_pkg::OP_COP1, mcrs_pkg::COP1_BC, 5'd1, 16'h0004), 1'b0);
    push_word(enc_i(mcrs_pkg::OP_COP1, 5'h1F, 5'd1, 16'h0004), 1'b0);   // not a branch group
    push_word({OP_UNUSED, 26'h3FF_FFFF}, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    wait_idle();

    // New base without a reload: the program counter carries on
    set_window(32'h0000_0000, 32'h0000_0000);
    add_random(330, 1'b0);
    wait_idle();

    // Window runs past the top of the address space; the program counter wraps
    set_window(32'hFFFF_FFF0, 32'h1000_0000);
    add_random(330, 1'b1);
    wait_idle();

    set_window(32'hFFFF_FFFF, 32'h0000_0001);
    add_random(280, 1'b1);
    wait_idle();

    set_window($urandom, $urandom_range(0, 32'h1000_0000));
    add_random(330, 1'b1);
    wait_idle();

    set_window(32'h0000_0000, 32'h1000_0000);
    add_random(330, 1'b1);
    wait_idle();

    // Closing stretch at full rate on both sides
    set_window($urandom, $urandom_range(32'h100, 32'h0010_0000));
    calm = 1'b1;
    add_random(220, 1'b1);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && scan_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: predict on acceptance, hold a stalled word, idle in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        scan_q.push_back(scan_word(word_q[0].word, word_q[0].start));
        void'(word_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          in_valid_i    <= 1'b1;
          instr_word_i  <= word_q[0].word;
          image_start_i <= word_q[0].start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest scan; stall in bursts and,
  // twice in the run, hold off long enough for the block to back up its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (scan_q.size() == 0) begin
          $error("result item with no scan waiting: instr_address %h", instr_address_o);
          mismatch_count++;
        end else begin
          head = scan_q.pop_front();
          check_field("instr_address", head.addr, instr_address_o);
          check_field("is_branch", {31'd0, head.is_branch}, {31'd0, is_branch_o});
          check_field("is_call", {31'd0, head.is_call}, {31'd0, is_call_o});
          check_field("call_target", {4'd0, head.target}, {4'd0, call_target_o});
          check_field("new_function", {31'd0, head.new_func}, {31'd0, new_function_o});
          check_field("is_address_ref", {31'd0, head.ref_hit}, {31'd0, is_address_ref_o});
          check_field("ref_value", head.value, ref_value_o);
          check_field("branch_total", head.branches, branch_total_o);
          check_field("call_total", head.calls, call_total_o);
          check_field("ref_total", head.refs, ref_total_o);
          results_seen++;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && results_seen >= next_hold_at) begin
        hold_left = 59;
        next_hold_at += 800;
        out_stall_i <= 1'b1;
      end else if (stall_gap != 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_gap = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: abandon the run after too long with no item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
